[sv/assert_macros.svh]
// Assertion macros of the sorted priority queue RTL.
// Depends on nothing; included by sorted_priority_queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst is low.
`define SPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Checks a property on every rising edge of clk, reset included.
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

[sv/spq_pkg.sv]
// Types and codes of the sorted priority queue.
// Depends on nothing; used by spq_cell, sorted_priority_queue and the testbench.
package spq_pkg;

   // Width of the fill level in a result word.
   localparam int FILL_W = 5;

   // Request kinds.
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_POP    = 1'b1
   } req_kind_type;

   // Status codes of a result word.
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell in a cycle.
   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_POP    = 2'd2
   } cmd_op_type;

   typedef struct packed {
      req_kind_type       req_type;
      logic signed [31:0] data_in;
      logic signed [31:0] priority_in;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data_out;
      logic [FILL_W-1:0]  fill_level;
   } rsp_word_type;

   typedef struct packed {
      cmd_op_type         op;
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } cell_cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic               valid;
      logic               gt;
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } cell_link_type;

endpackage

[sv/spq_cell.sv]
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::cell_cmd_type  cmd,
   input  spq_pkg::cell_link_type left,
   input  spq_pkg::cell_link_type right,
   output spq_pkg::cell_link_type own
);

   logic               valid_ff, valid_in;
   logic signed [31:0] data_ff, data_in;
   logic signed [31:0] prio_ff, prio_in;
   logic               gt;

   // The stored entry ranks behind the word being inserted.
   assign gt = valid_ff && (prio_ff > cmd.prio);

   // Next contents of the slot.
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      case (cmd.op)
         spq_pkg::CMD_INSERT: begin
            if (left.gt) begin
               // The insert point lies further up; shift the left entry in.
               valid_in = 1'b1;
               data_in  = left.data;
               prio_in  = left.prio;
            end else if (gt || (!valid_ff && left.valid)) begin
               // This slot is the insert point.
               valid_in = 1'b1;
               data_in  = cmd.data;
               prio_in  = cmd.prio;
            end
         end
         spq_pkg::CMD_POP: begin
            valid_in = right.valid;
            data_in  = right.data;
            prio_in  = right.prio;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign own = '{valid: valid_ff, gt: gt, data: data_ff, prio: prio_ff};

endmodule

[sv/sorted_priority_queue.sv]
// Top level of the sorted priority queue: a row of spq_cell slots and the
// fill counter. Depends on spq_pkg, spq_cell and assert_macros.svh.
//
// Usage:
//  - A request word (insert or pop) is taken at a rising edge where start
//    is high and busy is low. busy stays low: a request can be taken every
//    cycle, so one request per cycle is sustained.
//  - Each request gives one result word on rsp_word, marked by rsp_strobe for
//    exactly one cycle, in the cycle right after the request is taken.
//  - An insert is placed by all slots in parallel: each slot compares its
//    priority with the new one and either keeps its entry, takes the new
//    entry or takes its left neighbor's. A pop shifts every slot left by one.
//    Each request is completed by this single compare-and-shift step.
//  - Status reports done, pop on an empty queue, or insert dropped because
//    the queue is full; data_out is zero unless a pop succeeded.
//  - Reset (synchronous, active high) empties the queue; no clearing pass.
//  - The receiver cannot stall: a result word not taken in its cycle is lost.
`include "assert_macros.svh"

module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output spq_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_strobe_ff;
   spq_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   spq_pkg::cell_cmd_type cmd;
   spq_pkg::cell_link_type links [DEPTH];
   logic [DEPTH-1:0]      valid_vec;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == FULL_COUNT);
   assign empty  = (count_ff == '0);

   // Decode the request into a command for all slots and the result word.
   always_comb begin
      cmd.op      = spq_pkg::CMD_HOLD;
      cmd.data    = req_word.data_in;
      cmd.prio    = req_word.priority_in;
      count_in    = count_ff;
      rsp_word_in = rsp_word_ff;
      if (accept) begin
         rsp_word_in.status   = spq_pkg::STATUS_DONE;
         rsp_word_in.data_out = '0;
         case (req_word.req_type)
            spq_pkg::REQ_INSERT: begin
               if (full) begin
                  rsp_word_in.status = spq_pkg::STATUS_FULL;
               end else begin
                  cmd.op   = spq_pkg::CMD_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            spq_pkg::REQ_POP: begin
               if (empty) begin
                  rsp_word_in.status = spq_pkg::STATUS_EMPTY;
               end else begin
                  cmd.op               = spq_pkg::CMD_POP;
                  count_in             = count_ff - 1'b1;
                  rsp_word_in.data_out = links[0].data;
               end
            end
            default: begin
            end
         endcase
         rsp_word_in.fill_level = spq_pkg::FILL_W'(count_in);
      end
   end

   // Row of slots, head at index zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      spq_pkg::cell_link_type left_link;
      spq_pkg::cell_link_type right_link;

      if (i == 0) begin : g_head
         assign left_link = '{valid: 1'b1, gt: 1'b0, data: '0, prio: '0};
      end else begin : g_body
         assign left_link = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_link = '{valid: 1'b0, gt: 1'b0, data: '0, prio: '0};
      end else begin : g_inner
         assign right_link = links[i+1];
      end

      spq_cell u_slot (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (left_link),
         .right (right_link),
         .own   (links[i])
      );

      assign valid_vec[i] = links[i].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Every taken request gives a result word in the next cycle.
   `SPQ_ASSERT(a_rsp_follows_req, clock, reset, accept |=> rsp_strobe)
   // The fill counter matches the number of occupied slots.
   `SPQ_ASSERT(a_count_matches, clock, reset, $countones(valid_vec) == count_ff)
   // An empty-queue pop reports an empty queue and no data.
   `SPQ_ASSERT(a_empty_pop, clock, reset, (rsp_strobe && rsp_word.status == spq_pkg::STATUS_EMPTY) |-> (rsp_word.fill_level == '0 && rsp_word.data_out == '0))
   // The queue never reports busy, reset included.
   `SPQ_ASSERT_ALWAYS(a_never_busy, clock, !busy)

endmodule

[tb/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: directed table, then random traffic.
// Depends on spq_pkg and the sorted_priority_queue RTL; a shadow queue predicts every result word.
module tb_sorted_priority_queue;

   localparam int DEPTH        = 16;
   localparam int RANDOM_WORDS = 1450;
   localparam int CYCLE_LIMIT  = 200000;

   // One row of the directed table; rsp is used only where exp_given is set.
   typedef struct {
      spq_pkg::req_word_type word;
      bit                    exp_given;
      spq_pkg::rsp_word_type rsp;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   spq_pkg::req_word_type req_word;
   logic                  rsp_strobe;
   spq_pkg::rsp_word_type rsp_word;

   // Shadow copy of the queue contents, kept sorted by ascending priority.
   logic signed [31:0] held_data [DEPTH];
   logic signed [31:0] held_prio [DEPTH];
   int                 held = 0;

   spq_pkg::rsp_word_type awaited_rsp[$];
   table_row_type         directed_rows[$];
   int                    error_count = 0;
   int                    cycles = 0;
   int                    n_insert = 0;
   int                    n_pop = 0;
   int                    n_empty = 0;
   int                    n_full = 0;
   int                    peak_fill = 0;

   sorted_priority_queue #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Applies one request to the shadow queue and returns the word it should produce.
   function automatic spq_pkg::rsp_word_type next_rsp_word(input spq_pkg::req_word_type w);
      spq_pkg::rsp_word_type r;
      int slot;
      int i;
      r.status = spq_pkg::STATUS_DONE;
      r.data_out = '0;
      if (w.req_type == spq_pkg::REQ_INSERT) begin
         if (held >= DEPTH) begin
            r.status = spq_pkg::STATUS_FULL;
         end else begin
            // The new entry goes behind every entry of equal or lower priority.
            slot = 0;
            while (slot < held && $signed(held_prio[slot]) <= $signed(w.priority_in))
               slot++;
            for (i = held; i > slot; i--) begin
               held_data[i] = held_data[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_data[slot] = w.data_in;
            held_prio[slot] = w.priority_in;
            held++;
         end
      end else begin
         if (held == 0) begin
            r.status = spq_pkg::STATUS_EMPTY;
         end else begin
            r.data_out = held_data[0];
            for (i = 1; i < held; i++) begin
               held_data[i-1] = held_data[i];
               held_prio[i-1] = held_prio[i];
            end
            held--;
         end
      end
      r.fill_level = spq_pkg::FILL_W'(held);
      return r;
   endfunction

   // Presents one word after an idle gap and waits until the block takes it.
   task automatic issue_word(input spq_pkg::req_word_type w, input int gap,
                             input bit exp_given, input spq_pkg::rsp_word_type given_rsp);
      spq_pkg::rsp_word_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      // Inputs and busy are stable at the falling edge, so this decides the next rise.
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      predicted = next_rsp_word(w);
      awaited_rsp.push_back(exp_given ? given_rsp : predicted);
      if (w.req_type == spq_pkg::REQ_INSERT) n_insert++;
      else n_pop++;
      if (predicted.status == spq_pkg::STATUS_EMPTY) n_empty++;
      if (predicted.status == spq_pkg::STATUS_FULL) n_full++;
      if (held > peak_fill) peak_fill = held;
      @(posedge clock);
   endtask

   // Each strobed word is compared field by field with the oldest expectation.
   always @(negedge clock) begin
      spq_pkg::rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result word, got status %0d data %0d fill %0d",
                     $time, rsp_word.status, rsp_word.data_out, rsp_word.fill_level);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_word.status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_word.status);
            end
            if (rsp_word.data_out !== want.data_out) begin
               error_count++;
               $display("%0t: data_out expected %0d, got %0d",
                        $time, want.data_out, rsp_word.data_out);
            end
            if (rsp_word.fill_level !== want.fill_level) begin
               error_count++;
               $display("%0t: fill_level expected %0d, got %0d",
                        $time, want.fill_level, rsp_word.fill_level);
            end
         end
      end
   end

   // Stimulus: directed table first, then random bursts that swing the fill level.
   initial begin
      spq_pkg::req_word_type w;
      spq_pkg::rsp_word_type none;
      int sent;
      int burst;
      int insert_pct;
      bit idle_on;
      int k;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      none = '0;

      // Pop on the empty queue, extreme data and priorities, ties, a full queue, then pops.
      directed_rows.push_back('{'{spq_pkg::REQ_POP, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b1,
                                '{spq_pkg::STATUS_EMPTY, 32'sd0, 5'd0}});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF}, 1'b1,
                                '{spq_pkg::STATUS_DONE, 32'sd0, 5'd1}});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000}, 1'b1,
                                '{spq_pkg::STATUS_DONE, 32'sd0, 5'd2}});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'shFFFF_FFFF, 32'sd0}, 1'b1,
                                '{spq_pkg::STATUS_DONE, 32'sd0, 5'd3}});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sd0, 32'sd0}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00A4, -32'sd1}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00A5, 32'sd1}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00A6, 32'sh7FFF_FFFF},
                                1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00A7, 32'sh8000_0000},
                                1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00A8, 32'sd5}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00A9, 32'sd5}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00AA, 32'sd5}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh5555_5555, -32'sd5}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'shAAAA_AAAA, 32'sh4000_0000},
                                1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00AD, 32'shC000_0000},
                                1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00AE, 32'sd0}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'sh0000_00AF, 32'sd2}, 1'b1,
                                '{spq_pkg::STATUS_DONE, 32'sd0, 5'd16}});
      directed_rows.push_back('{'{spq_pkg::REQ_INSERT, 32'shFFFF_FFFF, 32'sh8000_0000}, 1'b1,
                                '{spq_pkg::STATUS_FULL, 32'sd0, 5'd16}});
      directed_rows.push_back('{'{spq_pkg::REQ_POP, 32'sd0, 32'sd0}, 1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_POP, 32'shFFFF_FFFF, 32'shFFFF_FFFF},
                                1'b0, none});
      directed_rows.push_back('{'{spq_pkg::REQ_POP, 32'sd0, 32'sd0}, 1'b0, none});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_word(directed_rows[i].word, $urandom_range(0, 4),
                    directed_rows[i].exp_given, directed_rows[i].rsp);

      // Bursts lean toward inserts, toward pops or neither, so the queue fills and drains.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 50;
            default: insert_pct = 15;
         endcase
         idle_on = ($urandom_range(0, 2) != 0);
         for (k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
            w.req_type = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::REQ_INSERT
                                                              : spq_pkg::REQ_POP;
            w.data_in = $urandom;
            // Mix wide priorities, a narrow band that makes ties common, and extreme values.
            case ($urandom_range(0, 3))
               0, 1: w.priority_in = $urandom;
               2: w.priority_in = 32'($urandom_range(0, 6)) - 32'd3;
               default: begin
                  case ($urandom_range(0, 3))
                     0: w.priority_in = 32'sh8000_0000;
                     1: w.priority_in = 32'sh7FFF_FFFF;
                     2: w.priority_in = 32'sd0;
                     default: w.priority_in = -32'sd1;
                  endcase
               end
            endcase
            issue_word(w, idle_on ? $urandom_range(0, 4) : 0, 1'b0, none);
            sent++;
         end
      end
      start <= 1'b0;

      // Drain the outstanding words, then wait for stray strobes.
      while (awaited_rsp.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);

      $display("Covered %0d inserts and %0d pops; %0d pops hit an empty queue,",
               n_insert, n_pop, n_empty);
      $display("%0d inserts were dropped on a full queue, peak fill level %0d.",
               n_full, peak_fill);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
